FILE: hdl/cascaded_fourth_order_iir_filter_defines.svh
// Assertion macros for the cascaded fourth-order IIR filter.
// Included by the top level; the macros expect signals named clk and rst_n in scope.
`ifndef CASCADED_FOURTH_ORDER_IIR_FILTER_DEFINES_SVH
`define CASCADED_FOURTH_ORDER_IIR_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CFIIR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define CFIIR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CFIIR_ASSERT_IMPL(name, ante, cons)
`define CFIIR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: hdl/cfiir_pkg.sv
// Shared types and constants of the cascaded fourth-order IIR filter.
// No dependencies; used by the top level and the testbench.
package cfiir_pkg;

    localparam int NUM_SECTIONS_DEF = 4;
    localparam int COEFS_PER_SEC    = 9;
    localparam int TAPS             = 4;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int DELAY_W  = 40;
    localparam int GAIN_W   = 24;
    localparam int ACC_W    = 48;

    localparam int SPLIT         = 20;
    localparam int MUL_B_W       = SPLIT + 1;
    localparam int MUL_W         = COEF_W + MUL_B_W;
    localparam int Q_W           = MUL_W + 1;
    localparam int COEF_SHIFT_LO = 27 - SPLIT;
    localparam int GAIN_SHIFT_LO = 23 - SPLIT;

    localparam int SEC_FIELD_W = 3;
    localparam int SLOT_W      = 4;
    localparam int S_TDATA_W   = 64;
    localparam int SEC_LSB     = SAMPLE_W;
    localparam int SLOT_LSB    = SEC_LSB + SEC_FIELD_W;
    localparam int VALUE_LSB   = SLOT_LSB + SLOT_W;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h80_0000;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_A_LAST = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_B0     = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_B1     = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_B_LAST = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_DRAIN,
        ST_SATW,
        ST_SATY,
        ST_GLO,
        ST_GHI,
        ST_GOUT
    } state_t;

endpackage

FILE: hdl/cascaded_fourth_order_iir_filter.sv
// Top level of the cascaded fourth-order IIR filter with one shared multiplier.
// Depends on cfiir_pkg and cascaded_fourth_order_iir_filter_defines.svh.
//
// A sample beat (tuser 0) runs through NUM_SECTIONS direct form II sections and the output
// gain, and gives one output beat; a coefficient beat (tuser 1) loads one Q4.27 coefficient
// if its section and slot are in range and gives none. A sample keeps the block busy while
// the single 32 x 21 multiplier forms each of the nine products of a section in two halves,
// and through one drain and one saturation step per half section. Every coefficient of every
// section must be written before the first sample; the delay lines start at zero. The result
// waits in an output register while the next beat is taken.
`include "cascaded_fourth_order_iir_filter_defines.svh"

module cascaded_fourth_order_iir_filter #(
    parameter int NUM_SECTIONS = cfiir_pkg::NUM_SECTIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_in[23:0], coef_section[26:24], coef_slot[30:27], coef_value[62:31]
    input  logic [cfiir_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sample_out[23:0]
    output logic [cfiir_pkg::SAMPLE_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfiir_pkg::GAIN_W-1:0]      cfg_data
);

    localparam int COEF_DEPTH = NUM_SECTIONS * cfiir_pkg::COEFS_PER_SEC;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int SEC_W      = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int WR_W       = cfiir_pkg::SEC_FIELD_W + cfiir_pkg::SLOT_W;
    localparam int ACC_W      = cfiir_pkg::ACC_W;
    localparam int DELAY_W    = cfiir_pkg::DELAY_W;
    localparam int Q_W        = cfiir_pkg::Q_W;
    localparam int SAMPLE_W   = cfiir_pkg::SAMPLE_W;
    localparam int COEF_W     = cfiir_pkg::COEF_W;
    localparam int MUL_W      = cfiir_pkg::MUL_W;
    localparam int SPLIT      = cfiir_pkg::SPLIT;

    localparam logic [SEC_W-1:0] LAST_SEC  = SEC_W'(NUM_SECTIONS - 1);
    localparam logic [CA_W-1:0]  BASE_STEP = CA_W'(cfiir_pkg::COEFS_PER_SEC);
    localparam logic [CA_W-1:0]  BASE_LAST =
        CA_W'((NUM_SECTIONS - 1) * cfiir_pkg::COEFS_PER_SEC);

    localparam logic signed [ACC_W-1:0] ACC_DMAX =
        {{(ACC_W - DELAY_W + 1){1'b0}}, {(DELAY_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_DMIN =
        {{(ACC_W - DELAY_W + 1){1'b1}}, {(DELAY_W - 1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_OMAX =
        {{(Q_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_OMIN =
        {{(Q_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

    cfiir_pkg::state_t state_reg, state_next;

    logic [cfiir_pkg::SLOT_W-1:0]  op_reg, op_next, op_inc;
    logic [SEC_W-1:0]              sec_reg, sec_next, rd_sec;
    logic [CA_W-1:0]               base_reg, base_next, coef_rd_addr;
    logic                          pend_reg, pend_next;
    logic                          pend_sub_reg, pend_sub_next;
    logic                          out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]           out_data_reg, out_data_next;
    logic [cfiir_pkg::GAIN_W-1:0]  gain_reg;

    logic signed [ACC_W-1:0]       acc_reg, acc_next, acc_sum, p_coef;
    logic signed [DELAY_W-1:0]     w_reg, w_next, zop_reg, zop_next, acc_sat, zop_dly;
    logic signed [MUL_W-1:0]       prod_lo_reg, prod_hi_reg, mul_p;
    logic signed [COEF_W-1:0]      coef_rd_reg, mul_a;
    logic signed [cfiir_pkg::MUL_B_W-1:0] mul_b;
    logic signed [Q_W-1:0]         q_sum, g_val;
    logic [SAMPLE_W-1:0]           gain_sat;
    logic [1:0]                    rd_k;

    logic signed [COEF_W-1:0]      coef_mem [COEF_DEPTH];
    logic signed [DELAY_W-1:0]     dly_reg [NUM_SECTIONS][cfiir_pkg::TAPS];

    logic signed [SAMPLE_W-1:0]            in_sample;
    logic [cfiir_pkg::SEC_FIELD_W-1:0]     wr_sec;
    logic [cfiir_pkg::SLOT_W-1:0]          wr_slot;
    logic signed [COEF_W-1:0]              wr_value;
    logic [WR_W-1:0]                       wr_lin;
    logic                                  wr_ok, coef_we, dly_shift, mul_hi, use_gain;

    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign wr_sec    = s_tdata[cfiir_pkg::SLOT_LSB-1:cfiir_pkg::SEC_LSB];
    assign wr_slot   = s_tdata[cfiir_pkg::VALUE_LSB-1:cfiir_pkg::SLOT_LSB];
    assign wr_value  = s_tdata[cfiir_pkg::VALUE_LSB+COEF_W-1:cfiir_pkg::VALUE_LSB];
    assign wr_lin    = WR_W'(wr_sec) * WR_W'(cfiir_pkg::COEFS_PER_SEC) + WR_W'(wr_slot);
    assign wr_ok     = ({1'b0, wr_sec} < (cfiir_pkg::SEC_FIELD_W + 1)'(NUM_SECTIONS))
                    && (wr_slot < cfiir_pkg::SLOT_W'(cfiir_pkg::COEFS_PER_SEC));

    assign s_tready  = (state_reg == cfiir_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Shared multiplier: coefficient or gain times one 20-bit half of the operand word.
    assign use_gain = (state_reg == cfiir_pkg::ST_GLO) || (state_reg == cfiir_pkg::ST_GHI);
    assign mul_hi   = (state_reg == cfiir_pkg::ST_HI) || (state_reg == cfiir_pkg::ST_GHI);
    assign mul_a    = use_gain ? signed'({{(COEF_W - cfiir_pkg::GAIN_W){1'b0}}, gain_reg})
                               : coef_rd_reg;
    assign mul_b    = mul_hi ? signed'({zop_reg[DELAY_W-1], zop_reg[DELAY_W-1:SPLIT]})
                             : signed'({1'b0, zop_reg[SPLIT-1:0]});
    assign mul_p    = MUL_W'(mul_a) * MUL_W'(mul_b);

    // Exact floor of the full product over 2^20, then the final shift.
    assign q_sum  = Q_W'(prod_hi_reg) + Q_W'(prod_lo_reg >>> SPLIT);
    assign p_coef = ACC_W'(q_sum >>> cfiir_pkg::COEF_SHIFT_LO);
    assign g_val  = q_sum >>> cfiir_pkg::GAIN_SHIFT_LO;
    assign acc_sum = pend_sub_reg ? (acc_reg - p_coef) : (acc_reg + p_coef);

    always_comb
    begin
        if (acc_reg > ACC_DMAX)
        begin
            acc_sat = DELAY_W'(ACC_DMAX);
        end
        else if (acc_reg < ACC_DMIN)
        begin
            acc_sat = DELAY_W'(ACC_DMIN);
        end
        else
        begin
            acc_sat = acc_reg[DELAY_W-1:0];
        end
    end

    always_comb
    begin
        if (g_val > Q_OMAX)
        begin
            gain_sat = SAMPLE_W'(Q_OMAX);
        end
        else if (g_val < Q_OMIN)
        begin
            gain_sat = SAMPLE_W'(Q_OMIN);
        end
        else
        begin
            gain_sat = g_val[SAMPLE_W-1:0];
        end
    end

    // Operand and coefficient fetch for the product that starts in the next cycle.
    always_comb
    begin
        op_inc       = op_reg + 1'b1;
        rd_sec       = sec_reg;
        rd_k         = 2'd0;
        coef_rd_addr = base_reg + CA_W'(op_reg);
        case (state_reg)
            cfiir_pkg::ST_IDLE:
            begin
                rd_sec       = '0;
                coef_rd_addr = '0;
            end
            cfiir_pkg::ST_HI:
            begin
                rd_k         = (op_inc >= cfiir_pkg::SLOT_B1) ? 2'(op_inc - cfiir_pkg::SLOT_B1)
                                                              : op_inc[1:0];
                coef_rd_addr = base_reg + CA_W'(op_inc);
            end
            cfiir_pkg::ST_SATW:
            begin
                coef_rd_addr = base_reg + CA_W'(cfiir_pkg::SLOT_B0);
            end
            cfiir_pkg::ST_SATY:
            begin
                rd_sec       = (sec_reg == LAST_SEC) ? '0 : sec_reg + 1'b1;
                coef_rd_addr = (base_reg == BASE_LAST) ? '0 : base_reg + BASE_STEP;
            end
            default:
            begin
            end
        endcase
        zop_dly = dly_reg[rd_sec][rd_k];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfiir_pkg::ST_IDLE:
            begin
                if (s_tvalid && (s_tuser == cfiir_pkg::REQ_SAMPLE))
                begin
                    state_next = cfiir_pkg::ST_LO;
                end
            end
            cfiir_pkg::ST_LO:
            begin
                state_next = cfiir_pkg::ST_HI;
            end
            cfiir_pkg::ST_HI:
            begin
                if ((op_reg == cfiir_pkg::SLOT_A_LAST) || (op_reg == cfiir_pkg::SLOT_B_LAST))
                begin
                    state_next = cfiir_pkg::ST_DRAIN;
                end
                else
                begin
                    state_next = cfiir_pkg::ST_LO;
                end
            end
            cfiir_pkg::ST_DRAIN:
            begin
                if (op_reg == cfiir_pkg::SLOT_A_LAST)
                begin
                    state_next = cfiir_pkg::ST_SATW;
                end
                else
                begin
                    state_next = cfiir_pkg::ST_SATY;
                end
            end
            cfiir_pkg::ST_SATW:
            begin
                state_next = cfiir_pkg::ST_LO;
            end
            cfiir_pkg::ST_SATY:
            begin
                if (sec_reg == LAST_SEC)
                begin
                    state_next = cfiir_pkg::ST_GLO;
                end
                else
                begin
                    state_next = cfiir_pkg::ST_LO;
                end
            end
            cfiir_pkg::ST_GLO:
            begin
                state_next = cfiir_pkg::ST_GHI;
            end
            cfiir_pkg::ST_GHI:
            begin
                state_next = cfiir_pkg::ST_GOUT;
            end
            cfiir_pkg::ST_GOUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = cfiir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfiir_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        sec_next       = sec_reg;
        base_next      = base_reg;
        acc_next       = pend_reg ? acc_sum : acc_reg;
        w_next         = w_reg;
        zop_next       = zop_reg;
        pend_next      = 1'b0;
        pend_sub_next  = pend_sub_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        coef_we        = 1'b0;
        dly_shift      = 1'b0;
        case (state_reg)
            cfiir_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == cfiir_pkg::REQ_SAMPLE)
                    begin
                        acc_next  = ACC_W'(in_sample);
                        zop_next  = zop_dly;
                        op_next   = '0;
                        sec_next  = '0;
                        base_next = '0;
                    end
                    else
                    begin
                        coef_we = wr_ok;
                    end
                end
            end
            cfiir_pkg::ST_HI:
            begin
                pend_next     = 1'b1;
                pend_sub_next = (op_reg <= cfiir_pkg::SLOT_A_LAST);
                if ((op_reg != cfiir_pkg::SLOT_A_LAST) && (op_reg != cfiir_pkg::SLOT_B_LAST))
                begin
                    op_next  = op_inc;
                    zop_next = zop_dly;
                end
            end
            cfiir_pkg::ST_SATW:
            begin
                w_next   = acc_sat;
                zop_next = acc_sat;
                acc_next = '0;
                op_next  = cfiir_pkg::SLOT_B0;
            end
            cfiir_pkg::ST_SATY:
            begin
                dly_shift = 1'b1;
                if (sec_reg == LAST_SEC)
                begin
                    zop_next = acc_sat;
                end
                else
                begin
                    acc_next  = ACC_W'(acc_sat);
                    zop_next  = zop_dly;
                    sec_next  = sec_reg + 1'b1;
                    base_next = base_reg + BASE_STEP;
                    op_next   = '0;
                end
            end
            cfiir_pkg::ST_GOUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = gain_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfiir_pkg::ST_IDLE;
            op_reg        <= '0;
            sec_reg       <= '0;
            base_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_sub_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gain_reg      <= cfiir_pkg::GAIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            sec_reg       <= sec_next;
            base_reg      <= base_next;
            pend_reg      <= pend_next;
            pend_sub_reg  <= pend_sub_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                gain_reg <= cfg_data;
            end
        end
    end

    // The low half is kept while a finished sample waits for the output register.
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        w_reg        <= w_next;
        zop_reg      <= zop_next;
        out_data_reg <= out_data_next;
        if ((state_reg == cfiir_pkg::ST_LO) || (state_reg == cfiir_pkg::ST_GLO))
        begin
            prod_lo_reg <= mul_p;
        end
        else if (mul_hi)
        begin
            prod_hi_reg <= mul_p;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[wr_lin[CA_W-1:0]] <= wr_value;
        end
        coef_rd_reg <= coef_mem[coef_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SECTIONS; s++)
            begin
                for (int k = 0; k < cfiir_pkg::TAPS; k++)
                begin
                    dly_reg[s][k] <= '0;
                end
            end
        end
        else if (dly_shift)
        begin
            for (int s = 0; s < NUM_SECTIONS; s++)
            begin
                if (sec_reg == SEC_W'(s))
                begin
                    for (int k = cfiir_pkg::TAPS - 1; k > 0; k--)
                    begin
                        dly_reg[s][k] <= dly_reg[s][k-1];
                    end
                    dly_reg[s][0] <= w_reg;
                end
            end
        end
    end

    `CFIIR_ASSERT_IMPL(a_pend_consumed, pend_reg,
        (state_reg == cfiir_pkg::ST_LO) || (state_reg == cfiir_pkg::ST_DRAIN))
    `CFIIR_ASSERT_NEXT(a_sample_starts,
        s_tvalid && s_tready && (s_tuser == cfiir_pkg::REQ_SAMPLE),
        (state_reg == cfiir_pkg::ST_LO) && (op_reg == '0) && (sec_reg == '0))
    `CFIIR_ASSERT_IMPL(a_base_tracks_sec, state_reg != cfiir_pkg::ST_IDLE,
        base_reg == CA_W'(sec_reg) * BASE_STEP)
    `CFIIR_ASSERT_NEXT(a_result_waits,
        (state_reg == cfiir_pkg::ST_GOUT) && m_tvalid && !m_tready,
        state_reg == cfiir_pkg::ST_GOUT)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the cascaded fourth-order IIR filter: directed and random beats,
// each output checked against a listed value or a fixed-point predictor of cascade and gain.
// Depends on cfiir_pkg and cascaded_fourth_order_iir_filter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W      = cfiir_pkg::SAMPLE_W;
    localparam int COEF_W        = cfiir_pkg::COEF_W;
    localparam int DELAY_W       = cfiir_pkg::DELAY_W;
    localparam int GAIN_W        = cfiir_pkg::GAIN_W;
    localparam int SLOT_W        = cfiir_pkg::SLOT_W;
    localparam int SEC_FIELD_W   = cfiir_pkg::SEC_FIELD_W;
    localparam int S_TDATA_W     = cfiir_pkg::S_TDATA_W;
    localparam int SEC_LSB       = cfiir_pkg::SEC_LSB;
    localparam int SLOT_LSB      = cfiir_pkg::SLOT_LSB;
    localparam int VALUE_LSB     = cfiir_pkg::VALUE_LSB;
    localparam int COEFS_PER_SEC = cfiir_pkg::COEFS_PER_SEC;
    localparam int TAPS          = cfiir_pkg::TAPS;

    localparam logic REQ_SAMPLE = cfiir_pkg::REQ_SAMPLE;
    localparam logic REQ_COEF   = cfiir_pkg::REQ_COEF;

    localparam logic [SLOT_W-1:0] SLOT_A_LAST = cfiir_pkg::SLOT_A_LAST;
    localparam logic [SLOT_W-1:0] SLOT_B0     = cfiir_pkg::SLOT_B0;
    localparam logic [SLOT_W-1:0] SLOT_B1     = cfiir_pkg::SLOT_B1;
    localparam logic [SLOT_W-1:0] SLOT_B_LAST = cfiir_pkg::SLOT_B_LAST;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = cfiir_pkg::GAIN_RESET;

    localparam int NS               = cfiir_pkg::NUM_SECTIONS_DEF;
    localparam int SETTLE_CYCLES    = 100;
    localparam int HOLD_OFF_CYCLES  = 3000;
    localparam int STALL_LIMIT      = 20000;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 210;

    localparam logic [SLOT_W-1:0] SLOT_A1  = 4'd0;
    localparam logic [COEF_W-1:0] COEF_ONE = 32'h0800_0000;

    localparam longint DELAY_HI = (longint'(1) <<< (DELAY_W - 1)) - 1;
    localparam longint DELAY_LO = -DELAY_HI - 1;
    localparam longint OUT_HI   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_LO   = -OUT_HI - 1;

    typedef struct packed {
        logic                   kind;
        logic [SAMPLE_W-1:0]    sample;
        logic [SEC_FIELD_W-1:0] section;
        logic [SLOT_W-1:0]      slot;
        logic [COEF_W-1:0]      value;
        logic                   typed;
        logic [SAMPLE_W-1:0]    expected;
    } beat_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [SAMPLE_W-1:0]     m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [GAIN_W-1:0]       cfg_data;

    logic signed [COEF_W-1:0]  coef_bank [NS*COEFS_PER_SEC];
    logic signed [DELAY_W-1:0] delay_line [NS*TAPS];
    logic [GAIN_W-1:0]         gain_setting;
    logic [SAMPLE_W-1:0]       pending_outputs [$];
    logic [SAMPLE_W-1:0]       out_expected;
    int                        mismatch_count;
    bit                        src_idling;
    bit                        sink_idling;
    bit                        hold_off_req;

    beat_row_t directed_rows [23] = '{
        '{REQ_SAMPLE, 24'h00_0000, 3'd0, SLOT_A1, 32'h0, 1'b1, 24'h00_0000},
        '{REQ_SAMPLE, 24'h7F_FFFF, 3'd0, SLOT_A1, 32'h0, 1'b1, 24'h7F_FFFF},
        '{REQ_SAMPLE, 24'h80_0000, 3'd0, SLOT_A1, 32'h0, 1'b1, 24'h80_0000},
        '{REQ_SAMPLE, 24'h00_0001, 3'd0, SLOT_A1, 32'h0, 1'b1, 24'h00_0001},
        '{REQ_SAMPLE, 24'hFF_FFFF, 3'd0, SLOT_A1, 32'h0, 1'b1, 24'hFF_FFFF},
        '{REQ_COEF, 24'h00_0000, SEC_FIELD_W'(NS), SLOT_B0, 32'h0, 1'b0, 24'h0},
        '{REQ_COEF, 24'h00_0000, 3'd0, SLOT_B_LAST + 4'd1, 32'h0, 1'b0, 24'h0},
        '{REQ_COEF, 24'h00_0000, SEC_FIELD_W'(NS - 1), 4'hF, 32'h0, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h00_3039, 3'd7, 4'hF, 32'hFFFF_FFFF, 1'b1, 24'h00_3039},
        '{REQ_COEF, 24'h00_0000, 3'd0, SLOT_B0, 32'h1000_0000, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h40_0000, 3'd0, SLOT_A1, 32'h0, 1'b1, 24'h7F_FFFF},
        '{REQ_SAMPLE, 24'hC0_0000, 3'd0, SLOT_A1, 32'h0, 1'b1, 24'h80_0000},
        '{REQ_SAMPLE, 24'h80_0000, 3'd0, SLOT_A1, 32'h0, 1'b1, 24'h80_0000},
        '{REQ_COEF, 24'h00_0000, 3'd1, SLOT_A1, 32'hFC00_0000, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h7F_FFFF, 3'd0, SLOT_A1, 32'h0, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h00_0000, 3'd0, SLOT_A1, 32'h0, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h00_0000, 3'd0, SLOT_A1, 32'h0, 1'b0, 24'h0},
        '{REQ_COEF, 24'h00_0000, 3'd2, SLOT_B_LAST, 32'h7FFF_FFFF, 1'b0, 24'h0},
        '{REQ_COEF, 24'h00_0000, 3'd2, SLOT_A_LAST, 32'h8000_0000, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h80_0000, 3'd0, SLOT_A1, 32'h0, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h7F_FFFF, 3'd0, SLOT_A1, 32'h0, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h7F_FFFF, 3'd0, SLOT_A1, 32'h0, 1'b0, 24'h0},
        '{REQ_SAMPLE, 24'h80_0000, 3'd0, SLOT_A1, 32'h0, 1'b0, 24'h0}
    };

    cascaded_fourth_order_iir_filter #(
        .NUM_SECTIONS(NS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [S_TDATA_W-1:0] pack_beat(beat_row_t r);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[SAMPLE_W-1:0] = r.sample;
        d[SEC_LSB +: SEC_FIELD_W] = r.section;
        d[SLOT_LSB +: SLOT_W] = r.slot;
        d[VALUE_LSB +: COEF_W] = r.value;
        return d;
    endfunction

    function automatic bit lands_in_bank(beat_row_t r);
        return r.kind == REQ_COEF && r.section < NS && r.slot <= SLOT_B_LAST;
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Exact product of a Q4.27 coefficient and a Q17.23 word, floored back to Q17.23.
    function automatic longint scaled_product(logic signed [COEF_W-1:0] c,
                                              logic signed [DELAY_W-1:0] z);
        logic signed [71:0] wide_c;
        logic signed [71:0] wide_z;
        logic signed [71:0] prod;
        wide_c = c;
        wide_z = z;
        prod = (wide_c * wide_z) >>> 27;
        return longint'(prod);
    endfunction

    function automatic logic [SAMPLE_W-1:0] run_cascade(logic signed [SAMPLE_W-1:0] sample);
        longint                    signal_val;
        longint                    acc;
        logic signed [DELAY_W-1:0] w;
        logic signed [71:0]        wide_y;
        logic signed [71:0]        wide_g;
        logic signed [71:0]        scaled;
        int                        base_c;
        int                        base_z;
        signal_val = sample;
        for (int s = 0; s < NS; s++)
        begin
            base_c = s * COEFS_PER_SEC;
            base_z = s * TAPS;
            acc = signal_val;
            for (int k = 0; k < TAPS; k++)
                acc -= scaled_product(coef_bank[base_c + k], delay_line[base_z + k]);
            w = DELAY_W'(clamp_to(acc, DELAY_LO, DELAY_HI));
            acc = scaled_product(coef_bank[base_c + SLOT_B0], w);
            for (int k = 0; k < TAPS; k++)
                acc += scaled_product(coef_bank[base_c + SLOT_B1 + k], delay_line[base_z + k]);
            for (int k = TAPS - 1; k > 0; k--)
                delay_line[base_z + k] = delay_line[base_z + k - 1];
            delay_line[base_z] = w;
            signal_val = clamp_to(acc, DELAY_LO, DELAY_HI);
        end
        wide_y = signal_val;
        wide_g = {48'd0, gain_setting};
        scaled = (wide_y * wide_g) >>> 23;
        return SAMPLE_W'(clamp_to(longint'(scaled), OUT_LO, OUT_HI));
    endfunction

    function automatic void apply_beat(beat_row_t r);
        logic [SAMPLE_W-1:0] result;
        if (r.kind == REQ_COEF)
        begin
            if (lands_in_bank(r))
                coef_bank[r.section * COEFS_PER_SEC + r.slot] = r.value;
        end
        else
        begin
            result = run_cascade(r.sample);
            pending_outputs.push_back(r.typed ? r.expected : result);
        end
    endfunction

    // Small a-coefficients keep every section stable; the b-coefficients stay within one half.
    function automatic logic [COEF_W-1:0] tame_coef(logic [SLOT_W-1:0] slot);
        int span;
        span = (slot <= SLOT_A_LAST) ? (1 << 24) : (1 << 26);
        return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic beat_row_t random_row();
        beat_row_t r;
        int        pick;
        r = '0;
        r.kind = ($urandom_range(0, 99) < 82) ? REQ_SAMPLE : REQ_COEF;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            r.sample = 24'h7F_FFFF;
        else if (pick < 8)
            r.sample = 24'h80_0000;
        else
            r.sample = SAMPLE_W'($urandom);
        r.section = ($urandom_range(0, 99) < 85) ? SEC_FIELD_W'($urandom_range(0, NS - 1))
                                                 : SEC_FIELD_W'($urandom_range(0, 7));
        r.slot = ($urandom_range(0, 99) < 90) ? SLOT_W'($urandom_range(0, SLOT_B_LAST))
                                              : SLOT_W'($urandom_range(0, 15));
        r.value = ($urandom_range(0, 99) < 10) ? COEF_W'($urandom) : tame_coef(r.slot);
        return r;
    endfunction

    task automatic send_row(beat_row_t r);
        s_tvalid <= 1'b1;
        s_tuser <= r.kind;
        s_tdata <= pack_beat(r);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_beat(r);
        if (src_idling && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 120))
                @(posedge clk);
        end
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] g);
        cfg_valid <= 1'b1;
        cfg_data <= g;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        gain_setting = g;
    endtask

    task automatic load_coefs(int mode);
        beat_row_t r;
        for (int s = 0; s < NS; s++)
        begin
            for (int k = 0; k <= SLOT_B_LAST; k++)
            begin
                r = '0;
                r.kind = REQ_COEF;
                r.sample = SAMPLE_W'($urandom);
                r.section = SEC_FIELD_W'(s);
                r.slot = SLOT_W'(k);
                if (mode == 0)
                    r.value = (r.slot == SLOT_B0) ? COEF_ONE : '0;
                else if (mode == 1)
                    r.value = tame_coef(r.slot);
                else
                    r.value = COEF_W'($urandom);
                send_row(r);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("sample_out: expected no beat, got %0d", $signed(m_tdata));
                mismatch_count++;
            end
            else
            begin
                out_expected = pending_outputs.pop_front();
                if (m_tdata !== out_expected)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(out_expected), $signed(m_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                m_tready <= !sink_idling || ($urandom_range(0, 99) >= 33);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("cascaded_fourth_order_iir_filter test failed");
        $finish;
    end

    initial
    begin
        logic [GAIN_W-1:0] phase_gain [PHASES];
        beat_row_t         row;
        int                counted;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= REQ_SAMPLE;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        mismatch_count = 0;
        src_idling = 1'b1;
        sink_idling = 1'b1;
        hold_off_req = 1'b0;
        gain_setting = GAIN_RESET;
        foreach (coef_bank[i])
            coef_bank[i] = '0;
        foreach (delay_line[i])
            delay_line[i] = '0;
        phase_gain = '{24'h00_0000, 24'hFF_FFFF, GAIN_RESET, GAIN_W'($urandom),
                       24'h00_0001, GAIN_W'($urandom)};
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_coefs(0);
        foreach (directed_rows[i])
            send_row(directed_rows[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_outputs();
            write_gain(phase_gain[p]);
            src_idling = (p != 2);
            sink_idling = (p != 2);
            if (p == 3)
                hold_off_req = 1'b1;
            load_coefs((p == 4) ? 2 : 1);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                row = random_row();
                send_row(row);
                if (row.kind == REQ_SAMPLE || lands_in_bank(row))
                    counted++;
            end
        end
        drain_outputs();

        if (mismatch_count == 0)
            $display("cascaded_fourth_order_iir_filter test passed");
        else
            $display("cascaded_fourth_order_iir_filter test failed");
        $finish;
    end
endmodule

FILE: cascaded_fourth_order_iir_filter.f
+incdir+hdl
hdl/cfiir_pkg.sv
hdl/cascaded_fourth_order_iir_filter.sv
tb/testbench.sv
